// ----- rtl/timed_packet_hold_buffer_defines.svh -----
// ----------------------------------------------------------------------------
// timed_packet_hold_buffer_defines
// assertion macros used by the hold buffer datapath
// ----------------------------------------------------------------------------
`ifndef TIMED_PACKET_HOLD_BUFFER_DEFINES_SVH
`define TIMED_PACKET_HOLD_BUFFER_DEFINES_SVH

`ifndef SYNTH
`define TPHB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define TPHB_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define TPHB_ASSERT(name, prop, msg)
`define TPHB_ASSERT_IMP(name, ante, cons, msg)
`endif

`endif

// ----- rtl/tphb_pkg.sv -----
// ----------------------------------------------------------------------------
// tphb_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package tphb_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] CMD_ENQ   = 2'd0;
  localparam logic [1:0] CMD_SWEEP = 2'd1;
  localparam logic [1:0] CMD_DROP  = 2'd2;
  localparam logic [1:0] CMD_SEND  = 2'd3;

  localparam logic [2:0] KIND_EVICT  = 3'd0;
  localparam logic [2:0] KIND_EXPIRE = 3'd1;
  localparam logic [2:0] KIND_SEND   = 3'd2;
  localparam logic [2:0] KIND_DROP   = 3'd3;
  localparam logic [2:0] KIND_SUM    = 3'd4;

  localparam logic REG_MAX_LEN = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  localparam logic [4:0]  MAX_LEN_RST = 5'd16;
  localparam logic [31:0] TIMEOUT_RST = 32'd30000000;

  typedef struct packed {
    logic load_cmd;
    logic step;
    logic load_sum;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic cur_remove;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/tphb_ctrl.sv -----
// ----------------------------------------------------------------------------
// tphb_ctrl
// command sequencer: accept, walk over stored entries, summary
// ----------------------------------------------------------------------------
`default_nettype none

module tphb_ctrl import tphb_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_cmd = 1'b1;
          state_d        = ST_WALK;
        end
      end
      ST_WALK: begin
        if (stat_i.walk_done) begin
          state_d = ST_FIN;
        end else if (!stat_i.cur_remove || stat_i.out_free) begin
          cmd_o.step = 1'b1;
        end
      end
      ST_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.load_sum = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tphb_dp.sv -----
// ----------------------------------------------------------------------------
// tphb_dp
// entry store, walk counters, timer and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "timed_packet_hold_buffer_defines.svh"

module tphb_dp import tphb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] now_i,
  input  wire logic [31:0] dest_addr_i,
  input  wire logic [15:0] packet_handle_i,
  input  wire dp_cmd_t     cmd_i,
  output dp_stat_t         stat_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       kind_o,
  output logic [15:0]      out_handle_o,
  output logic [31:0]      out_dest_o,
  output logic [4:0]       removed_count_o,
  output logic             timer_armed_o,
  output logic [31:0]      next_deadline_o,
  output logic             last_o
);

  logic [31:0] slot_dest   [DEPTH];
  logic [15:0] slot_handle [DEPTH];
  logic [31:0] slot_time   [DEPTH];

  logic [4:0]       max_len_q;
  logic [31:0]      timeout_q;
  logic [1:0]       cmd_q;
  logic [31:0]      now_q, dest_q;
  logic [15:0]      handle_q;
  logic [CNT_W-1:0] i_q, w_q, cnt_q, removed_q;
  logic             found_q;
  logic [31:0]      best_age_q, best_time_q;
  logic             tmr_on_q;
  logic [31:0]      tmr_dl_q;
  logic [31:0]      cur_dest_q, cur_time_q;
  logic [15:0]      cur_handle_q;

  logic             out_valid_q, out_last_q, out_armed_q;
  logic [2:0]       out_kind_q;
  logic [15:0]      out_handle_q;
  logic [31:0]      out_dest_q, out_dl_q;
  logic [4:0]       out_cnt_q;

  logic [IDX_W-1:0] rd_idx;
  logic [31:0]      age;
  logic [CNT_W-1:0] lim, base;
  logic             evict, expired, remove, out_free, better;
  logic [2:0]       rm_kind;
  logic             tmr_on_n;
  logic [31:0]      tmr_dl_n;

  // read address follows the next walk index so cur_* holds entry i_q
  always_comb begin
    if (cmd_i.load_cmd) begin
      rd_idx = '0;
    end else if (cmd_i.step) begin
      rd_idx = i_q[IDX_W-1:0] + IDX_W'(1);
    end else begin
      rd_idx = i_q[IDX_W-1:0];
    end
  end

  assign age        = now_q - cur_time_q;
  assign expired    = age > timeout_q;
  assign better     = !found_q || (age > best_age_q);

  // limit clamped to 1..DEPTH
  always_comb begin
    if (max_len_q == '0) begin
      lim = CNT_W'(1);
    end else if (32'(max_len_q) > DEPTH) begin
      lim = CNT_W'(DEPTH);
    end else begin
      lim = CNT_W'(max_len_q);
    end
  end

  assign evict = (cnt_q != '0) && (cnt_q >= lim);

  always_comb begin
    case (cmd_q)
      CMD_ENQ:   begin remove = (i_q == '0); rm_kind = KIND_EVICT;  end
      CMD_SWEEP: begin remove = expired;     rm_kind = KIND_EXPIRE; end
      CMD_SEND:  begin remove = (cur_dest_q == dest_q); rm_kind = KIND_SEND; end
      default:   begin remove = (cur_dest_q == dest_q); rm_kind = KIND_DROP; end
    endcase
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign stat_o.walk_done  = (i_q == cnt_q) || ((cmd_q == CMD_ENQ) && !evict);
  assign stat_o.cur_remove = remove;
  assign stat_o.out_free   = out_free;

  // enqueue appends behind the kept entries
  assign base = evict ? w_q : cnt_q;

  always_comb begin
    tmr_on_n = tmr_on_q;
    tmr_dl_n = tmr_dl_q;
    case (cmd_q)
      CMD_ENQ: begin
        if (cnt_q == '0) begin
          tmr_on_n = 1'b1;
          tmr_dl_n = now_q;
        end
      end
      CMD_SWEEP: begin
        tmr_on_n = found_q;
        tmr_dl_n = found_q ? best_time_q + timeout_q : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RST;
      timeout_q <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX_LEN: max_len_q <= cfg_data_i[4:0];
        REG_TIMEOUT: timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      i_q       <= '0;
      w_q       <= '0;
      removed_q <= '0;
      found_q   <= 1'b0;
      tmr_on_q  <= 1'b0;
      tmr_dl_q  <= '0;
    end else begin
      if (cmd_i.load_cmd) begin
        i_q       <= '0;
        w_q       <= '0;
        removed_q <= '0;
        found_q   <= 1'b0;
      end
      if (cmd_i.step) begin
        i_q <= i_q + CNT_W'(1);
        if (remove) begin
          removed_q <= removed_q + CNT_W'(1);
        end else begin
          w_q <= w_q + CNT_W'(1);
          if ((cmd_q == CMD_SWEEP) && better) begin
            found_q <= 1'b1;
          end
        end
      end
      if (cmd_i.load_sum) begin
        cnt_q    <= (cmd_q == CMD_ENQ) ? base + CNT_W'(1) : w_q;
        tmr_on_q <= tmr_on_n;
        tmr_dl_q <= tmr_on_n ? tmr_dl_n : '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_cmd) begin
      cmd_q    <= command_i;
      now_q    <= now_i;
      dest_q   <= dest_addr_i;
      handle_q <= packet_handle_i;
    end
    if (cmd_i.step && !remove && (cmd_q == CMD_SWEEP) && better) begin
      best_age_q  <= age;
      best_time_q <= cur_time_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_dest_q   <= slot_dest[rd_idx];
    cur_handle_q <= slot_handle[rd_idx];
    cur_time_q   <= slot_time[rd_idx];
    if (cmd_i.step && !remove) begin
      slot_dest[w_q[IDX_W-1:0]]   <= cur_dest_q;
      slot_handle[w_q[IDX_W-1:0]] <= cur_handle_q;
      slot_time[w_q[IDX_W-1:0]]   <= cur_time_q;
    end else if (cmd_i.load_sum && (cmd_q == CMD_ENQ)) begin
      slot_dest[base[IDX_W-1:0]]   <= dest_q;
      slot_handle[base[IDX_W-1:0]] <= handle_q;
      slot_time[base[IDX_W-1:0]]   <= now_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.step && remove) || cmd_i.load_sum) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && remove) begin
      out_kind_q   <= rm_kind;
      out_handle_q <= cur_handle_q;
      out_dest_q   <= cur_dest_q;
      out_cnt_q    <= '0;
      out_armed_q  <= 1'b0;
      out_dl_q     <= '0;
      out_last_q   <= 1'b0;
    end else if (cmd_i.load_sum) begin
      out_kind_q   <= KIND_SUM;
      out_handle_q <= '0;
      out_dest_q   <= '0;
      out_cnt_q    <= 5'(removed_q);
      out_armed_q  <= tmr_on_n;
      out_dl_q     <= tmr_on_n ? tmr_dl_n : '0;
      out_last_q   <= 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_kind_q;
  assign out_handle_o    = out_handle_q;
  assign out_dest_o      = out_dest_q;
  assign removed_count_o = out_cnt_q;
  assign timer_armed_o   = out_armed_q;
  assign next_deadline_o = out_dl_q;
  assign last_o          = out_last_q;

  `TPHB_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "entry count above depth")
  `TPHB_ASSERT_IMP(a_tmr_off_zero, !tmr_on_q, tmr_dl_q == '0, "disarmed timer has deadline")
  `TPHB_ASSERT(a_wr_behind_rd, w_q <= i_q, "compaction write pointer ahead of read")

endmodule

`default_nettype wire

// ----- rtl/timed_packet_hold_buffer.sv -----
// ----------------------------------------------------------------------------
// timed_packet_hold_buffer
// hold buffer for packet handles waiting for a route, with timeout eviction
// ----------------------------------------------------------------------------
// input words on s_axis: tuser carries the command, tdata the timestamp,
// destination and handle. results on m_axis: tuser is the result kind, tlast
// marks the summary that closes every command.
// one command at a time: s_axis_tready is high only while the sequencer is
// idle. after acceptance the walk steps over every stored entry (enqueue
// without eviction walks none), then the walk state sees its end and the
// finish state loads the summary into the result register; s_axis_tready
// returns once the sequencer is back in idle. the walk reads one entry per
// cycle and compacts in place. each removal is loaded into the result
// register as the walk steps past its entry; the summary follows the walk.
// a stalled m_axis holds the result register and pauses the walk at the
// next removal or before the summary.
// reset empties the buffer, disarms the timer and loads max_len 16 and
// timeout 30000000 ticks. cfg writes are registered; the user must make them
// only while no command is in progress, as the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_packet_hold_buffer import tphb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,   // now, dest_addr, packet_handle
  input  wire logic [1:0]  s_axis_tuser,   // command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [87:0]      m_axis_tdata,   // out_handle, out_dest, removed_count,
                                           // timer_armed, next_deadline, pad
  output logic [2:0]       m_axis_tuser,   // kind
  output logic             m_axis_tlast    // last
);

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [15:0] out_handle;
  logic [31:0] out_dest, next_deadline;
  logic [4:0]  removed_count;
  logic        timer_armed;

  tphb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tphb_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .command_i       (s_axis_tuser),
    .now_i           (s_axis_tdata[31:0]),
    .dest_addr_i     (s_axis_tdata[63:32]),
    .packet_handle_i (s_axis_tdata[79:64]),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .kind_o          (m_axis_tuser),
    .out_handle_o    (out_handle),
    .out_dest_o      (out_dest),
    .removed_count_o (removed_count),
    .timer_armed_o   (timer_armed),
    .next_deadline_o (next_deadline),
    .last_o          (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, next_deadline, timer_armed, removed_count, out_dest, out_handle};

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the timed packet hold buffer: a clocked driver feeds
// commands from a queue, a shadow of the buffer predicts every removal and
// summary word, and a monitor compares each m_axis word in order. phases vary
// max_len, timeout and the idle/stall rates on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import tphb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE = DEPTH + 8;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] now;
    logic [31:0] dest;
    logic [15:0] handle;
  } hold_cmd_t;

  typedef struct {
    logic [2:0]  kind;
    logic [15:0] handle;
    logic [31:0] dest;
    logic [4:0]  removed;
    logic        armed;
    logic [31:0] deadline;
    logic        last;
  } hold_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;   // now, dest_addr, packet_handle
  logic [1:0]  s_axis_tuser = '0;   // command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;        // out_handle, out_dest, removed_count,
                                    // timer_armed, next_deadline, pad
  logic [2:0]  m_axis_tuser;        // kind
  logic        m_axis_tlast;

  timed_packet_hold_buffer dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow of the buffer
  logic [31:0] sh_dest [DEPTH];
  logic [15:0] sh_handle [DEPTH];
  logic [31:0] sh_time [DEPTH];
  int          sh_count = 0;
  logic        sh_armed = 1'b0;
  logic [31:0] sh_deadline = '0;
  logic [4:0]  sh_max_len = MAX_LEN_RST;
  logic [31:0] sh_timeout = TIMEOUT_RST;

  hold_cmd_t    pending_cmds [$];
  hold_result_t expected_words [$];
  hold_cmd_t    cur_cmd;
  bit           word_taken = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_requests = 0;
  int           hold_served = 0;
  int           hold_left = 0;
  int           errors = 0;
  int           cmds_done = 0;
  int           words_done = 0;
  int           removals_seen = 0;
  int           cycles = 0;
  logic [31:0]  t_now = 0;
  logic [31:0]  dest_pool [4];

  function automatic hold_result_t mk_result(logic [2:0] kind, logic [15:0] h,
                                             logic [31:0] d);
    hold_result_t r;
    r.kind = kind; r.handle = h; r.dest = d;
    r.removed = '0; r.armed = 1'b0; r.deadline = '0; r.last = 1'b0;
    return r;
  endfunction

  task automatic predict_command(input hold_cmd_t c);
    int removed;
    int w;
    int lim;
    bit found;
    logic [31:0] age;
    logic [31:0] best_age;
    hold_result_t r;
    removed = 0;
    case (c.cmd)
      CMD_ENQ: begin
        lim = sh_max_len;
        if (lim < 1) lim = 1;
        if (lim > DEPTH) lim = DEPTH;
        if (sh_count == 0) begin
          sh_armed = 1'b1;
          sh_deadline = c.now;
        end else if (sh_count >= lim) begin
          expected_words.push_back(mk_result(KIND_EVICT, sh_handle[0], sh_dest[0]));
          removed = 1;
          for (int i = 1; i < sh_count; i++) begin
            sh_dest[i-1] = sh_dest[i]; sh_handle[i-1] = sh_handle[i];
            sh_time[i-1] = sh_time[i];
          end
          sh_count--;
        end
        sh_dest[sh_count] = c.dest;
        sh_handle[sh_count] = c.handle;
        sh_time[sh_count] = c.now;
        sh_count++;
      end
      CMD_SWEEP: begin
        if (sh_count == 0) begin
          sh_armed = 1'b0;
        end else begin
          found = 0;
          best_age = '0;
          w = 0;
          for (int i = 0; i < sh_count; i++) begin
            age = c.now - sh_time[i];
            if (age > sh_timeout) begin
              expected_words.push_back(mk_result(KIND_EXPIRE, sh_handle[i], sh_dest[i]));
              removed++;
            end else begin
              if (!found || age > best_age) begin
                best_age = age;
                found = 1;
              end
              sh_dest[w] = sh_dest[i]; sh_handle[w] = sh_handle[i]; sh_time[w] = sh_time[i];
              w++;
            end
          end
          sh_count = w;
          sh_armed = found;
          if (found) sh_deadline = (c.now - best_age) + sh_timeout;
        end
      end
      default: begin
        w = 0;
        for (int i = 0; i < sh_count; i++) begin
          if (sh_dest[i] == c.dest) begin
            expected_words.push_back(mk_result((c.cmd == CMD_SEND) ? KIND_SEND : KIND_DROP,
                                               sh_handle[i], sh_dest[i]));
            removed++;
          end else begin
            sh_dest[w] = sh_dest[i]; sh_handle[w] = sh_handle[i]; sh_time[w] = sh_time[i];
            w++;
          end
        end
        sh_count = w;
      end
    endcase
    if (!sh_armed) sh_deadline = '0;
    r = mk_result(KIND_SUM, '0, '0);
    r.removed = removed[4:0];
    r.armed = sh_armed;
    r.deadline = sh_deadline;
    r.last = 1'b1;
    expected_words.push_back(r);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on word %0d: %s got %0h expected %0h", words_done, field, got, want);
    errors++;
  endtask

  // driver: stream side inputs change on the falling edge
  always @(negedge clk_i) begin
    hold_cmd_t c;
    logic nxt_valid;
    nxt_valid = s_axis_tvalid;
    if (!s_axis_tvalid || word_taken) begin
      nxt_valid = 1'b0;
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        c = pending_cmds.pop_front();
        cur_cmd = c;
        s_axis_tdata <= {c.handle, c.dest, c.now};
        s_axis_tuser <= c.cmd;
        nxt_valid = 1'b1;
      end
    end
    word_taken = 0;
    s_axis_tvalid <= nxt_valid;
    m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // long receiver hold-off, counted here
  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = 400;
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  // monitor: sample on the rising edge
  always @(posedge clk_i) begin
    hold_result_t want;
    if (rst_ni) begin
      cycles++;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_command(cur_cmd);
        word_taken = 1;
        cmds_done++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          $display("unexpected word: kind %0d", m_axis_tuser);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (m_axis_tuser !== want.kind) report_mismatch("kind", m_axis_tuser, want.kind);
          if (m_axis_tdata[15:0] !== want.handle)
            report_mismatch("handle", m_axis_tdata[15:0], want.handle);
          if (m_axis_tdata[47:16] !== want.dest)
            report_mismatch("dest", m_axis_tdata[47:16], want.dest);
          if (m_axis_tdata[52:48] !== want.removed)
            report_mismatch("removed_count", m_axis_tdata[52:48], want.removed);
          if (m_axis_tdata[53] !== want.armed)
            report_mismatch("timer_armed", m_axis_tdata[53], want.armed);
          if (m_axis_tdata[85:54] !== want.deadline)
            report_mismatch("next_deadline", m_axis_tdata[85:54], want.deadline);
          if (m_axis_tlast !== want.last) report_mismatch("last", m_axis_tlast, want.last);
          if (want.kind != KIND_SUM) removals_seen++;
        end
        words_done++;
      end
      if (cycles >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("timed_packet_hold_buffer regression: fail");
        $finish;
      end
    end
  end

  task automatic push_cmd(input logic [1:0] cmd, input logic [31:0] now,
                          input logic [31:0] dest, input logic [15:0] handle);
    hold_cmd_t c;
    c.cmd = cmd; c.now = now; c.dest = dest; c.handle = handle;
    pending_cmds.push_back(c);
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MAX_LEN) sh_max_len = data[4:0];
    else sh_timeout = data;
  endtask

  task automatic random_cmds(input int n, input int step_max);
    int sel;
    logic [31:0] now;
    logic [31:0] dest;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      t_now += $urandom_range(step_max);
      now = ($urandom_range(9) == 0) ? $urandom() : t_now;
      dest = ($urandom_range(7) == 0) ? $urandom() : dest_pool[$urandom_range(3)];
      if (sel < 50) push_cmd(CMD_ENQ, now, dest, $urandom());
      else if (sel < 70) push_cmd(CMD_SWEEP, now, $urandom(), $urandom());
      else if (sel < 85) push_cmd(CMD_DROP, now, dest, $urandom());
      else push_cmd(CMD_SEND, now, dest, $urandom());
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input logic [4:0] lim,
                           input logic [31:0] tmo, input int step_max, input bit hold);
    wait_drained();
    write_reg(REG_MAX_LEN, {27'd0, lim});
    write_reg(REG_TIMEOUT, tmo);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    if (hold) hold_requests++;
    random_cmds(45, step_max);
  endtask

  initial begin
    dest_pool[0] = 32'h0;
    dest_pool[1] = 32'hFFFF_FFFF;
    dest_pool[2] = $urandom();
    dest_pool[3] = $urandom();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // default registers: empty sweep, timestamp wrap, verdict misses
    push_cmd(CMD_SWEEP, 32'd5, 32'h0, 16'h0);
    push_cmd(CMD_ENQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    push_cmd(CMD_ENQ, 32'h0, 32'h0, 16'h0);
    push_cmd(CMD_DROP, 32'd1, 32'h1234_5678, 16'h0);
    push_cmd(CMD_SWEEP, 32'd30000000, 32'h0, 16'h0);
    push_cmd(CMD_SEND, 32'd2, 32'h0, 16'h0);
    push_cmd(CMD_SWEEP, 32'd7, 32'h0, 16'h0);
    wait_drained();

    // small limit: eviction, partial expiry, age equal to timeout kept
    write_reg(REG_MAX_LEN, 32'd2);
    write_reg(REG_TIMEOUT, 32'd10);
    push_cmd(CMD_ENQ, 32'd100, 32'hA, 16'h1);
    push_cmd(CMD_ENQ, 32'd101, 32'hB, 16'h2);
    push_cmd(CMD_ENQ, 32'd102, 32'hA, 16'h3);
    push_cmd(CMD_DROP, 32'd102, 32'hA, 16'h0);
    push_cmd(CMD_ENQ, 32'd103, 32'hA, 16'h4);
    push_cmd(CMD_SWEEP, 32'd112, 32'h0, 16'h0);
    push_cmd(CMD_SWEEP, 32'd113, 32'h0, 16'h0);
    wait_drained();

    // limit zero acts as one, one eviction per enqueue
    write_reg(REG_MAX_LEN, 32'd0);
    push_cmd(CMD_ENQ, 32'd120, 32'hC, 16'h5);
    push_cmd(CMD_ENQ, 32'd121, 32'hC, 16'h6);
    push_cmd(CMD_SEND, 32'd122, 32'hC, 16'h0);
    push_cmd(CMD_SWEEP, 32'd200, 32'h0, 16'h0);

    t_now = 32'hFFFF_F000;
    run_phase(0, 0, 5'd16, 32'd100, 20, 0);
    run_phase(73, 0, 5'd5, 32'd0, 3, 0);
    run_phase(0, 73, 5'd0, 32'd50, 15, 0);
    run_phase(16, 16, 5'd31, 32'hFFFF_FFFF, 30, 0);
    run_phase(0, 0, 5'd3, 32'd200, 40, 1);
    run_phase(16, 16, 5'd1, 32'd1000, 300, 0);
    run_phase(0, 0, 5'd16, 32'd300, 25, 0);
    wait_drained();

    $display("covered %0d commands, %0d result words, %0d removals", cmds_done,
             words_done, removals_seen);
    $display("limits 0..31, timeouts 0 to max, idle and stall phases, long hold-off");
    if (errors == 0) begin
      $display("timed_packet_hold_buffer regression: pass");
    end else begin
      $display("timed_packet_hold_buffer regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/tphb_pkg.sv
rtl/tphb_ctrl.sv
rtl/tphb_dp.sv
rtl/timed_packet_hold_buffer.sv
test/tb_top.sv
